// ===== sv/vgp_pkg.sv =====
package vgp_pkg;

  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_STEPS = (EXP_TABLE_DEPTH > 1) ? EXP_TABLE_DEPTH - 1 : 1;
  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  // index sum: 20-bit argument times EXP_STEPS plus rounding bias
  localparam int IDXP_W = 21 + IDX_W;

  localparam int unsigned Q_ONE = 65536;
  localparam int unsigned EXP_ARG_MAX = 8 * Q_ONE;
  localparam int unsigned EXP_BIAS = 4 * Q_ONE;

  localparam logic signed [31:0] Q_HALF = 32'sd32768;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;
  localparam logic signed [63:0] S64_HI = 64'sd2147483647;
  localparam logic signed [63:0] S64_LO = -64'sd2147483648;

  // register indexes on the configuration port
  localparam logic [2:0] REG_BASE_GAIN       = 3'd0;
  localparam logic [2:0] REG_EXTRA_GAIN      = 3'd1;
  localparam logic [2:0] REG_GAIN_SHAPE      = 3'd2;
  localparam logic [2:0] REG_INTEGRAL_GAIN   = 3'd3;
  localparam logic [2:0] REG_DERIVATIVE_GAIN = 3'd4;
  localparam logic [2:0] REG_WINDUP_GAIN     = 3'd5;
  localparam logic [2:0] REG_OUT_MAX         = 3'd6;
  localparam logic [2:0] REG_OUT_MIN         = 3'd7;

  // datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP    = 4'd0;
  localparam op_t OP_ERR    = 4'd1;
  localparam op_t OP_INDEX  = 4'd2;
  localparam op_t OP_GINV   = 4'd3;
  localparam op_t OP_KP     = 4'd4;
  localparam op_t OP_UP     = 4'd5;
  localparam op_t OP_ACC    = 4'd6;
  localparam op_t OP_UI     = 4'd7;
  localparam op_t OP_UD     = 4'd8;
  localparam op_t OP_PRE    = 4'd9;
  localparam op_t OP_FINISH = 4'd10;
  localparam op_t OP_CLEAR  = 4'd11;

  // multiplier operand pairs
  typedef logic [2:0] mul_sel_t;
  localparam mul_sel_t MS_NONE       = 3'd0;
  localparam mul_sel_t MS_SHAPE_MAG  = 3'd1;
  localparam mul_sel_t MS_EXTRA_GINV = 3'd2;
  localparam mul_sel_t MS_KP_ERR     = 3'd3;
  localparam mul_sel_t MS_KI_UP      = 3'd4;
  localparam mul_sel_t MS_KW_CLAMP   = 3'd5;
  localparam mul_sel_t MS_KD_DP      = 3'd6;

  typedef logic [3:0] step_t;
  localparam step_t STEP_CLEAR = 4'd15;

  typedef struct packed {
    op_t      op;
    mul_sel_t mul_sel;
    logic     jump_clear;
    step_t    target;
    logic     last;
  } uword_t;

  typedef struct packed {
    logic     fire;
    op_t      op;
    mul_sel_t mul_sel;
    logic     last;
  } ctrl_t;

  typedef struct packed {
    logic signed [31:0] base_gain;
    logic signed [31:0] extra_gain;
    logic [30:0]        gain_shape;
    logic signed [31:0] integral_gain;
    logic signed [31:0] derivative_gain;
    logic signed [31:0] windup_gain;
    logic signed [31:0] out_max;
    logic signed [31:0] out_min;
  } cfg_t;

  typedef logic [EXP_TABLE_DEPTH-1:0][16:0] exp_rom_t;

  // exp(-8*i/EXP_STEPS) in unsigned Q1.16, built from a Q2.30 step factor
  function automatic exp_rom_t build_exp_rom();
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] r;
    longint      q;
    exp_rom_t    rom;
    h = (64'd8 << 30) / 64'(EXP_STEPS);
    term = 64'd1 << 30;
    q = longint'(64'd1 << 30);
    r = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * h) >> 30) / 64'(k);
      if ((k % 2) == 1) q = q - longint'(term);
      else q = q + longint'(term);
    end
    if (q < 0) q = 0;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      rom[i] = 17'((r + (64'd1 << 13)) >> 14);
      r = (r * 64'(q) + (64'd1 << 29)) >> 30;
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S64_HI) return S32_MAX;
    else if (v < S64_LO) return S32_MIN;
    return 32'(v);
  endfunction

  // microprogram
  function automatic uword_t ucode(input step_t step);
    uword_t uw;
    uw = '{op: OP_NOP, mul_sel: MS_NONE, jump_clear: 1'b0, target: '0, last: 1'b0};
    unique case (step)
      4'd0:  begin
        uw.op = OP_ERR;
        uw.mul_sel = MS_SHAPE_MAG;
        uw.jump_clear = 1'b1;
        uw.target = STEP_CLEAR;
      end
      4'd1:  uw.op = OP_INDEX;
      4'd2:  uw.op = OP_GINV;
      4'd3:  uw.mul_sel = MS_EXTRA_GINV;
      4'd4:  uw.op = OP_KP;
      4'd5:  uw.mul_sel = MS_KP_ERR;
      4'd6:  uw.op = OP_UP;
      4'd7:  uw.mul_sel = MS_KI_UP;
      4'd8:  uw.op = OP_ACC;
      4'd9:  uw.mul_sel = MS_KW_CLAMP;
      4'd10: uw.op = OP_UI;
      4'd11: uw.mul_sel = MS_KD_DP;
      4'd12: uw.op = OP_UD;
      4'd13: uw.op = OP_PRE;
      4'd14: begin
        uw.op = OP_FINISH;
        uw.last = 1'b1;
      end
      STEP_CLEAR: begin
        uw.op = OP_CLEAR;
        uw.last = 1'b1;
      end
      default: uw.op = OP_NOP;
    endcase
    return uw;
  endfunction

endpackage

// ===== sv/vgp_seq.sv =====
module vgp_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           func,
  input  logic           out_free,
  output logic           busy,
  output vgp_pkg::ctrl_t ctrl
);
  import vgp_pkg::*;

  step_t  step;
  step_t  step_next;
  logic   func_r;
  logic   hold;
  uword_t uw;

  assign uw = ucode(step);
  // hold the final step until the output register is free
  assign hold = uw.last && !out_free;
  assign step_next = (uw.jump_clear && func_r) ? uw.target : step + 4'd1;

  assign ctrl.fire = busy && !hold;
  assign ctrl.op = uw.op;
  assign ctrl.mul_sel = uw.mul_sel;
  assign ctrl.last = uw.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      func_r <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      func_r <= func;
    end else if (ctrl.fire) begin
      if (uw.last) busy <= 1'b0;
      else step <= step_next;
    end
  end

  a_hold_step: assert property (@(posedge clk) disable iff (rst)
    busy && !ctrl.fire |=> $stable(step) && busy)
    else $error("step moved while held");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.fire && ctrl.last |=> !busy)
    else $error("sequencer still busy after last step");
  a_fire_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl.fire |-> busy && !start)
    else $error("step fired while idle");

endmodule

// ===== sv/vgp_datapath.sv =====
module vgp_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] reference,
  input  logic signed [31:0] feedback,
  input  vgp_pkg::cfg_t      cfg,
  input  vgp_pkg::ctrl_t     ctrl,
  output logic signed [31:0] drive,
  output logic               saturated
);
  import vgp_pkg::*;

  logic signed [31:0] reference_r;
  logic signed [31:0] feedback_r;
  logic signed [31:0] err_r;
  logic [IDX_W-1:0]   idx_r;
  logic               exp_zero_r;
  logic [16:0]        ginv_r;
  logic signed [31:0] kp_r;
  logic signed [31:0] up_r;
  logic signed [50:0] acc_r;
  logic signed [31:0] ui_r;
  logic signed [31:0] ud_r;
  logic signed [33:0] pre_r;
  logic signed [65:0] prod_r;

  logic signed [31:0] last_error;
  logic signed [31:0] integral_sum;
  logic signed [31:0] last_prop;
  logic signed [31:0] clamp_diff;

  logic signed [32:0] mag;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_out;
  logic signed [49:0] prod_shift;
  logic [IDXP_W-1:0]  idx_sum;
  logic signed [51:0] ui_sum;
  logic signed [31:0] ui_sat;
  logic signed [31:0] drv_val;
  logic               sat_val;

  assign mag = last_error[31] ? -33'(last_error) : 33'(last_error);
  assign prod_shift = prod_r[65:16];
  assign idx_sum = IDXP_W'(prod_r[35:16]) * IDXP_W'(EXP_STEPS) + IDXP_W'(EXP_BIAS);
  assign ui_sum = 52'(acc_r) + 52'(prod_shift);
  assign ui_sat = sat32(64'(ui_sum));
  assign mul_out = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul_sel)
      MS_SHAPE_MAG: begin
        mul_a = $signed({2'b00, cfg.gain_shape});
        mul_b = mag;
      end
      MS_EXTRA_GINV: begin
        mul_a = 33'(cfg.extra_gain);
        mul_b = $signed({16'd0, ginv_r});
      end
      MS_KP_ERR: begin
        mul_a = 33'(kp_r);
        mul_b = 33'(err_r);
      end
      MS_KI_UP: begin
        mul_a = 33'(cfg.integral_gain);
        mul_b = 33'(up_r);
      end
      MS_KW_CLAMP: begin
        mul_a = 33'(cfg.windup_gain);
        mul_b = 33'(clamp_diff);
      end
      MS_KD_DP: begin
        mul_a = 33'(cfg.derivative_gain);
        mul_b = 33'(up_r) - 33'(last_prop);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // upper limit is checked first and wins when both limits are exceeded
  always_comb begin
    drv_val = 32'(pre_r);
    sat_val = 1'b0;
    if (pre_r > 34'(cfg.out_max)) begin
      drv_val = cfg.out_max;
      sat_val = 1'b1;
    end else if (pre_r < 34'(cfg.out_min)) begin
      drv_val = cfg.out_min;
      sat_val = 1'b1;
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (start) begin
      reference_r <= reference;
      feedback_r <= feedback;
    end
    if (ctrl.fire && ctrl.mul_sel != MS_NONE) prod_r <= mul_out;
    if (ctrl.fire) begin
      unique case (ctrl.op)
        OP_ERR:   err_r <= sat32(64'(33'(reference_r) - 33'(feedback_r)));
        OP_INDEX: begin
          exp_zero_r <= prod_r[65:16] > 50'(EXP_ARG_MAX);
          idx_r <= idx_sum[19 +: IDX_W];
        end
        OP_GINV:  ginv_r <= 17'(Q_ONE) - (exp_zero_r ? 17'd0 : EXP_ROM[idx_r]);
        OP_KP:    kp_r <= sat32(64'(51'(cfg.base_gain) + 51'(prod_shift)));
        OP_UP:    up_r <= sat32(64'(prod_shift));
        OP_ACC:   acc_r <= 51'(integral_sum) + 51'(prod_shift);
        OP_UI: begin
          // drop the integral when it opposes the new error past one half
          if ((ui_sat > Q_HALF && err_r < 0) || (ui_sat < -Q_HALF && err_r > 0))
            ui_r <= '0;
          else
            ui_r <= ui_sat;
        end
        OP_UD:    ud_r <= sat32(64'(prod_shift));
        OP_PRE:   pre_r <= 34'(up_r) + 34'(ui_r) + 34'(ud_r);
        OP_FINISH: begin
          drive <= drv_val;
          saturated <= sat_val;
        end
        OP_CLEAR: begin
          drive <= '0;
          saturated <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      integral_sum <= '0;
      last_prop <= '0;
      clamp_diff <= '0;
    end else if (ctrl.fire) begin
      if (ctrl.op == OP_FINISH) begin
        clamp_diff <= sat32(64'(35'(drv_val) - 35'(pre_r)));
        last_prop <= up_r;
        integral_sum <= ui_r;
        last_error <= err_r;
      end else if (ctrl.op == OP_CLEAR) begin
        integral_sum <= '0;
      end
    end
  end

  a_clear: assert property (@(posedge clk) disable iff (rst)
    ctrl.fire && ctrl.op == OP_CLEAR |=> integral_sum == 0 && drive == 0 && !saturated)
    else $error("clear request left integral or output set");
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    ctrl.fire && ctrl.op == OP_FINISH && !sat_val |=> clamp_diff == 0)
    else $error("clamp difference set without saturation");

endmodule

// ===== sv/variable_gain_pid_step.sv =====
// channel  handshake               payload
// in       in_valid / in_stall     func, reference, feedback
// out      out_valid / out_stall   drive, saturated
// cfg      cfg_write               cfg_index, cfg_data
//
// A control step runs 15 microprogram steps, one per cycle unless the last step
// waits, with every product going through the single shared 33x33 multiplier; a
// clear request takes 2. A new request is taken the cycle after the result loads.
// Reset (rst, synchronous) zeroes controller state and loads default gains/limits.
// in_stall is high while a request is in work; the last step waits on out_stall
// only when the output register still holds an untaken result.
module variable_gain_pid_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic signed [31:0] reference,
  input  logic signed [31:0] feedback,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] drive,
  output logic               saturated,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import vgp_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;
  logic  busy;
  logic  start;
  logic  out_free;

  assign in_stall = busy;
  assign start = in_valid && !busy;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_gain <= '0;
      cfg.extra_gain <= '0;
      cfg.gain_shape <= '0;
      cfg.integral_gain <= '0;
      cfg.derivative_gain <= '0;
      cfg.windup_gain <= '0;
      cfg.out_max <= 32'sd65536;
      cfg.out_min <= -32'sd65536;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE_GAIN:       cfg.base_gain <= cfg_data;
        REG_EXTRA_GAIN:      cfg.extra_gain <= cfg_data;
        REG_GAIN_SHAPE:      cfg.gain_shape <= cfg_data[30:0];
        REG_INTEGRAL_GAIN:   cfg.integral_gain <= cfg_data;
        REG_DERIVATIVE_GAIN: cfg.derivative_gain <= cfg_data;
        REG_WINDUP_GAIN:     cfg.windup_gain <= cfg_data;
        REG_OUT_MAX:         cfg.out_max <= cfg_data;
        REG_OUT_MIN:         cfg.out_min <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fire && ctrl.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  vgp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .func     (func),
    .out_free (out_free),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  vgp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .reference (reference),
    .feedback  (feedback),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .drive     (drive),
    .saturated (saturated)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.fire && ctrl.last |-> !out_valid || !out_stall)
    else $error("result loaded over an untaken result");

endmodule
